@@ rtl/core/slot_allocator_oldest_reclaim_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the slot allocator core
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef SLOT_ALLOCATOR_OLDEST_RECLAIM_CORE_MACROS_SVH
`define SLOT_ALLOCATOR_OLDEST_RECLAIM_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SORC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define SORC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/sorc_pkg.sv @@
// ----------------------------------------------------------------------------
// Slot allocator package
// Sizes, command codes, controller states and the controller command bundle.
// ----------------------------------------------------------------------------
package sorc_pkg;

    // Pool size and derived widths.
    localparam int POOL_SLOTS = 64;
    localparam int SLOT_W     = 6;
    localparam int CNT_W      = 7;
    localparam int GRP_W      = 8;
    localparam int GRP_SEL_W  = 3;
    localparam int NUM_GRP    = POOL_SLOTS / GRP_W;

    // Reset value of the slots-in-use register.
    localparam logic [CNT_W-1:0] CFG_RESET = 7'd64;

    // Item command codes.
    typedef enum logic {
        CMD_REQUEST = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_APPLY
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic apply;
    } t_dp_cmd;

endpackage

@@ rtl/core/sorc_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel interface
// Carries one command item: request a slot or release a named slot.
// ----------------------------------------------------------------------------
interface sorc_req_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [sorc_pkg::SLOT_W-1:0] slot_index;

    modport source (output valid, output command, output slot_index, input ready);
    modport sink   (input valid, input command, input slot_index, output ready);
endinterface

@@ rtl/core/sorc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel interface
// Carries one result item per command item.
// ----------------------------------------------------------------------------
interface sorc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        granted;
    logic [sorc_pkg::SLOT_W-1:0] granted_slot;
    logic                        reclaimed;
    logic [sorc_pkg::CNT_W-1:0]  active_count;

    modport source (output valid, output granted, output granted_slot,
                    output reclaimed, output active_count, input ready);
    modport sink   (input valid, input granted, input granted_slot,
                    input reclaimed, input active_count, output ready);
endinterface

@@ rtl/core/sorc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Configuration write interface
// Carries the write data of the slots-in-use register.
// ----------------------------------------------------------------------------
interface sorc_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [sorc_pkg::CNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/slot_allocator_oldest_reclaim_core.sv @@
// ----------------------------------------------------------------------------
// Slot allocator with oldest-first reclaim
// Top level: request, response and configuration channels around the
// controller and the datapath.
// ----------------------------------------------------------------------------
// From acceptance to a ready result, each item is captured, then the first
// level of the free-slot encoder and the reads of the linked-list memories are
// registered, and then the item commits. A new item is accepted only once the
// previous item has committed and the controller is back in its idle state;
// the commit waits while an earlier result is still held in the output
// register. A request grants the lowest free slot below slots_in_use, or else
// reclaims the oldest active slot; a release of an inactive slot changes
// nothing. Configuration writes are always accepted and must be issued only
// while the block is idle. No clearing pass is needed after reset.
module slot_allocator_oldest_reclaim_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sorc_req_if.sink    i_req,
    sorc_rsp_if.source  o_rsp,
    sorc_cfg_if.sink    i_cfg
);

    sorc_pkg::t_dp_cmd dp_cmd;

    // Configuration writes never stall.
    assign i_cfg.ready = 1'b1;

    // Sequencing.
    sorc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (dp_cmd)
    );

    // Allocation state and result.
    sorc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_command      (i_req.command),
        .i_slot_index   (i_req.slot_index),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_data     (i_cfg.data),
        .o_granted      (o_rsp.granted),
        .o_granted_slot (o_rsp.granted_slot),
        .o_reclaimed    (o_rsp.reclaimed),
        .o_active_count (o_rsp.active_count)
    );

endmodule

@@ rtl/core/sorc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Slot allocator controller
// Sequences each item through capture, evaluation and commit, and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module sorc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output sorc_pkg::t_dp_cmd o_cmd
);

    sorc_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             apply_ok;

    // The commit may proceed once the output register is free or being drained.
    assign apply_ok = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sorc_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = sorc_pkg::ST_EVAL;
            end
            sorc_pkg::ST_EVAL: begin
                n_state = sorc_pkg::ST_APPLY;
            end
            sorc_pkg::ST_APPLY: begin
                if (apply_ok) n_state = sorc_pkg::ST_IDLE;
            end
            default: begin
                n_state = sorc_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd.load  = 1'b0;
        o_cmd.apply = 1'b0;
        unique case (r_state)
            sorc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            sorc_pkg::ST_EVAL: begin
                o_cmd.apply = 1'b0;
            end
            sorc_pkg::ST_APPLY: begin
                o_cmd.apply = apply_ok;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // A fresh result sets valid; a taken result clears it.
    always_comb begin
        if (o_cmd.apply) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && !i_out_ready;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sorc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/core/sorc_dp.sv @@
// ----------------------------------------------------------------------------
// Slot allocator datapath
// Active flags, two-level free-slot encoder, the age list kept as a doubly
// linked list in two memories, the slots-in-use register and the result.
// ----------------------------------------------------------------------------
module sorc_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sorc_pkg::t_dp_cmd           i_cmd,
    input  logic                        i_command,
    input  logic [sorc_pkg::SLOT_W-1:0] i_slot_index,
    input  logic                        i_cfg_we,
    input  logic [sorc_pkg::CNT_W-1:0]  i_cfg_data,
    output logic                        o_granted,
    output logic [sorc_pkg::SLOT_W-1:0] o_granted_slot,
    output logic                        o_reclaimed,
    output logic [sorc_pkg::CNT_W-1:0]  o_active_count
);

    // Control state.
    logic [sorc_pkg::POOL_SLOTS-1:0] r_active, n_active;
    logic [sorc_pkg::CNT_W-1:0]      r_len, n_len;
    logic [sorc_pkg::CNT_W-1:0]      r_cfg;

    // Captured item and list ends.
    sorc_pkg::t_cmd                  r_cmd;
    logic [sorc_pkg::SLOT_W-1:0]     r_idx;
    logic [sorc_pkg::SLOT_W-1:0]     r_head, n_head;
    logic [sorc_pkg::SLOT_W-1:0]     r_tail, n_tail;

    // Link memories and their registered read data.
    logic [sorc_pkg::SLOT_W-1:0]     r_next_mem [sorc_pkg::POOL_SLOTS];
    logic [sorc_pkg::SLOT_W-1:0]     r_prev_mem [sorc_pkg::POOL_SLOTS];
    logic [sorc_pkg::SLOT_W-1:0]     r_next_idx_rd;
    logic [sorc_pkg::SLOT_W-1:0]     r_prev_idx_rd;
    logic [sorc_pkg::SLOT_W-1:0]     r_next_head_rd;

    logic                            next_we, prev_we;
    logic [sorc_pkg::SLOT_W-1:0]     next_waddr, next_wdata;
    logic [sorc_pkg::SLOT_W-1:0]     prev_waddr, prev_wdata;

    // Encoder stage registers.
    logic [sorc_pkg::NUM_GRP-1:0]    r_grp_any;
    logic [sorc_pkg::GRP_SEL_W-1:0]  r_grp_pos [sorc_pkg::NUM_GRP];
    logic [sorc_pkg::NUM_GRP-1:0]    grp_any;
    logic [sorc_pkg::GRP_SEL_W-1:0]  grp_pos [sorc_pkg::NUM_GRP];
    logic                            found;
    logic [sorc_pkg::SLOT_W-1:0]     free_slot;

    // Result.
    logic                            res_granted, res_reclaimed;
    logic [sorc_pkg::SLOT_W-1:0]     res_slot;
    logic                            r_granted, r_reclaimed;
    logic [sorc_pkg::SLOT_W-1:0]     r_granted_slot;
    logic [sorc_pkg::CNT_W-1:0]      r_active_count;

    // First stage of the encoder: lowest free slot below the limit per group.
    // Comparing against the raw register saturates the limit at the pool size.
    always_comb begin
        for (int g = 0; g < sorc_pkg::NUM_GRP; g++) begin
            grp_any[g] = 1'b0;
            grp_pos[g] = '0;
            for (int b = sorc_pkg::GRP_W - 1; b >= 0; b--) begin
                if (!r_active[g * sorc_pkg::GRP_W + b] &&
                    (sorc_pkg::CNT_W'(g * sorc_pkg::GRP_W + b) < r_cfg)) begin
                    grp_any[g] = 1'b1;
                    grp_pos[g] = sorc_pkg::GRP_SEL_W'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_any <= grp_any;
        r_grp_pos <= grp_pos;
    end

    // Second stage of the encoder: lowest group that has a free slot.
    always_comb begin
        found     = 1'b0;
        free_slot = '0;
        for (int g = sorc_pkg::NUM_GRP - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                found     = 1'b1;
                free_slot = {sorc_pkg::GRP_SEL_W'(g), r_grp_pos[g]};
            end
        end
    end

    // Link reads for the captured slot and the list head.
    always_ff @(posedge i_clk) begin
        r_next_idx_rd  <= r_next_mem[r_idx];
        r_prev_idx_rd  <= r_prev_mem[r_idx];
        r_next_head_rd <= r_next_mem[r_head];
    end

    // Commit logic for one item.
    always_comb begin
        n_active      = r_active;
        n_len         = r_len;
        n_head        = r_head;
        n_tail        = r_tail;
        next_we       = 1'b0;
        next_waddr    = r_tail;
        next_wdata    = '0;
        prev_we       = 1'b0;
        prev_waddr    = '0;
        prev_wdata    = r_tail;
        res_granted   = 1'b0;
        res_reclaimed = 1'b0;
        res_slot      = '0;
        unique case (r_cmd)
            sorc_pkg::CMD_REQUEST: begin
                if (found) begin
                    // Grant a free slot and append it at the tail.
                    n_active[free_slot] = 1'b1;
                    if (r_len != '0) begin
                        next_we    = 1'b1;
                        next_waddr = r_tail;
                        next_wdata = free_slot;
                    end else begin
                        n_head = free_slot;
                    end
                    prev_we     = 1'b1;
                    prev_waddr  = free_slot;
                    prev_wdata  = r_tail;
                    n_tail      = free_slot;
                    n_len       = r_len + 1'b1;
                    res_granted = 1'b1;
                    res_slot    = free_slot;
                end else if (r_len != '0) begin
                    // Reclaim the oldest slot and move it to the tail.
                    res_granted   = 1'b1;
                    res_reclaimed = 1'b1;
                    res_slot      = r_head;
                    if (r_len != sorc_pkg::CNT_W'(1)) begin
                        n_head     = r_next_head_rd;
                        next_we    = 1'b1;
                        next_waddr = r_tail;
                        next_wdata = r_head;
                        prev_we    = 1'b1;
                        prev_waddr = r_head;
                        prev_wdata = r_tail;
                        n_tail     = r_head;
                    end
                end
            end
            sorc_pkg::CMD_RELEASE: begin
                if (r_active[r_idx]) begin
                    // Unlink the slot; neighbors close the gap.
                    n_active[r_idx] = 1'b0;
                    if (r_idx == r_head) begin
                        n_head = r_next_idx_rd;
                    end else begin
                        next_we    = 1'b1;
                        next_waddr = r_prev_idx_rd;
                        next_wdata = r_next_idx_rd;
                    end
                    if (r_idx == r_tail) begin
                        n_tail = r_prev_idx_rd;
                    end else begin
                        prev_we    = 1'b1;
                        prev_waddr = r_next_idx_rd;
                        prev_wdata = r_prev_idx_rd;
                    end
                    n_len = r_len - 1'b1;
                end
            end
            default: begin
                n_len = r_len;
            end
        endcase
    end

    // Link memory writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && next_we) begin
            r_next_mem[next_waddr] <= next_wdata;
        end
        if (i_cmd.apply && prev_we) begin
            r_prev_mem[prev_waddr] <= prev_wdata;
        end
    end

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_len    <= '0;
            r_cfg    <= sorc_pkg::CFG_RESET;
        end else begin
            if (i_cmd.apply) begin
                r_active <= n_active;
                r_len    <= n_len;
            end
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    // Item capture, list ends and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= sorc_pkg::t_cmd'(i_command);
            r_idx <= i_slot_index;
        end
        if (i_cmd.apply) begin
            r_head         <= n_head;
            r_tail         <= n_tail;
            r_granted      <= res_granted;
            r_granted_slot <= res_slot;
            r_reclaimed    <= res_reclaimed;
            r_active_count <= n_len;
        end
    end

    assign o_granted      = r_granted;
    assign o_granted_slot = r_granted_slot;
    assign o_reclaimed    = r_reclaimed;
    assign o_active_count = r_active_count;

endmodule

@@ rtl/core/sorc_checker.sv @@
// ----------------------------------------------------------------------------
// Slot allocator port checker
// Watches the top-level ports for result consistency and sequencing.
// ----------------------------------------------------------------------------
`include "slot_allocator_oldest_reclaim_core_macros.svh"

module sorc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic                        i_rsp_granted,
    input logic [sorc_pkg::SLOT_W-1:0] i_rsp_granted_slot,
    input logic                        i_rsp_reclaimed,
    input logic [sorc_pkg::CNT_W-1:0]  i_rsp_active_count
);

    // A held result stays until it is taken.
    `SORC_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid)

    // One item at a time: no acceptance right after an acceptance.
    `SORC_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    // A result without a grant carries no slot and no reclaim.
    `SORC_ASSERT_SAME(a_no_grant, i_clk, i_rst_n, i_rsp_valid && !i_rsp_granted, (i_rsp_granted_slot == '0) && !i_rsp_reclaimed)

    // The active count never exceeds the pool.
    `SORC_ASSERT_SAME(a_count_max, i_clk, i_rst_n, i_rsp_valid, i_rsp_active_count <= sorc_pkg::CNT_W'(sorc_pkg::POOL_SLOTS))

endmodule

bind slot_allocator_oldest_reclaim_core sorc_checker u_sorc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_granted      (o_rsp.granted),
    .i_rsp_granted_slot (o_rsp.granted_slot),
    .i_rsp_reclaimed    (o_rsp.reclaimed),
    .i_rsp_active_count (o_rsp.active_count)
);
